### src/hfmb_pkg.sv
// Shared constants, types and constant tables of the Hann window FFT magnitude bank.
package hfmb_pkg;

	localparam int WINDOW      = 256;
	localparam int SAMPLE_BITS = 16;
	localparam int IDX_W       = $clog2(WINDOW);
	localparam int FFT_BITS    = $clog2(WINDOW + 1) - 1;
	localparam int FFT_LEN     = 1 << FFT_BITS;
	localparam int HALF_LEN    = FFT_LEN / 2;
	localparam int STG_W       = $clog2(FFT_BITS);
	localparam int DATA_W      = 25;
	localparam int CELL_W      = 2 * DATA_W;
	localparam int PROD_W      = 2 * DATA_W;
	localparam int COEF_W      = 16;
	localparam int MAG_W       = 24;
	localparam int ROOT_W      = 25;
	localparam int RAD_W       = 50;
	localparam int BIN_W       = 8;
	localparam int HANN_DEN    = WINDOW - 1;

	localparam longint Q30_ONE     = 64'sd1073741824;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam int TAYLOR_TERMS    = 12;

	localparam logic signed [PROD_W:0] DATA_MAX = (PROD_W+1)'(64'sd16777215);
	localparam logic signed [PROD_W:0] DATA_MIN = -(PROD_W+1)'(64'sd16777216);
	localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(64'sd16384);

	typedef logic [COEF_W-1:0] hann_tab_t [WINDOW];
	typedef logic signed [COEF_W-1:0] tw_tab_t [HALF_LEN];
	typedef struct packed {
		longint s;
		longint c;
	} sc_t;

	// sine series term n: divide by (2n)(2n+1)
	function automatic longint unsigned sin_div(input longint unsigned v, input int n);
		longint unsigned r;
		case (n)
			1:       r = v / 64'd6;
			2:       r = v / 64'd20;
			3:       r = v / 64'd42;
			4:       r = v / 64'd72;
			5:       r = v / 64'd110;
			6:       r = v / 64'd156;
			7:       r = v / 64'd210;
			8:       r = v / 64'd272;
			9:       r = v / 64'd342;
			10:      r = v / 64'd420;
			11:      r = v / 64'd506;
			12:      r = v / 64'd600;
			default: r = v;
		endcase
		return r;
	endfunction

	// cosine series term n: divide by (2n-1)(2n)
	function automatic longint unsigned cos_div(input longint unsigned v, input int n);
		longint unsigned r;
		case (n)
			1:       r = v / 64'd2;
			2:       r = v / 64'd12;
			3:       r = v / 64'd30;
			4:       r = v / 64'd56;
			5:       r = v / 64'd90;
			6:       r = v / 64'd132;
			7:       r = v / 64'd182;
			8:       r = v / 64'd240;
			9:       r = v / 64'd306;
			10:      r = v / 64'd380;
			11:      r = v / 64'd462;
			12:      r = v / 64'd552;
			default: r = v;
		endcase
		return r;
	endfunction

	// Taylor series at Q2.30 for x in [0, pi/2]
	function automatic sc_t taylor_sc(input longint unsigned x);
		longint unsigned x2;
		longint unsigned term;
		longint s;
		longint c;
		sc_t r;
		x2   = (x * x) >> 30;
		term = x;
		s    = longint'(x);
		for (int n = 1; n <= TAYLOR_TERMS; n++) begin
			term = sin_div((term * x2) >> 30, n);
			s    = (n % 2 == 1) ? s - longint'(term) : s + longint'(term);
		end
		term = longint'(Q30_ONE);
		c    = Q30_ONE;
		for (int n = 1; n <= TAYLOR_TERMS; n++) begin
			term = cos_div((term * x2) >> 30, n);
			c    = (n % 2 == 1) ? c - longint'(term) : c + longint'(term);
		end
		r.s = s;
		r.c = c;
		return r;
	endfunction

	function automatic sc_t quadrant(input sc_t v, input longint unsigned q);
		sc_t r;
		case (q % 4)
			0: begin r.s = v.s; r.c = v.c; end
			1: begin r.s = v.c; r.c = -v.s; end
			2: begin r.s = -v.s; r.c = -v.c; end
			default: begin r.s = -v.c; r.c = v.s; end
		endcase
		return r;
	endfunction

	// sin/cos of 2*pi*m/(WINDOW-1)
	function automatic sc_t sc_hann(input int m);
		longint unsigned m4, q, r, x;
		m4 = 4 * longint'(m % HANN_DEN);
		q  = m4 / HANN_DEN;
		r  = m4 - q * HANN_DEN;
		x  = (longint'(HALF_PI_Q30) * r + HANN_DEN / 2) / HANN_DEN;
		return quadrant(taylor_sc(x), q);
	endfunction

	// sin/cos of 2*pi*m/FFT_LEN
	function automatic sc_t sc_twid(input int m);
		longint unsigned m4, q, r, x;
		m4 = 4 * longint'(m % FFT_LEN);
		q  = m4 / FFT_LEN;
		r  = m4 - q * FFT_LEN;
		x  = (longint'(HALF_PI_Q30) * r + FFT_LEN / 2) / FFT_LEN;
		return quadrant(taylor_sc(x), q);
	endfunction

	function automatic logic signed [COEF_W-1:0] q30_to_q15(input longint v);
		longint t, r;
		t = v;
		if (t > Q30_ONE) t = Q30_ONE;
		if (t < -Q30_ONE) t = -Q30_ONE;
		r = ((t + Q30_ONE + 16384) >>> 15) - 32768;
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return COEF_W'(r);
	endfunction

	function automatic hann_tab_t build_hann();
		hann_tab_t t;
		sc_t v;
		longint w30, w15;
		for (int i = 0; i < WINDOW; i++) begin
			v   = sc_hann(i);
			w30 = (Q30_ONE - v.c) / 2;
			if (w30 < 0) w30 = 0;
			w15 = (w30 + 16384) >>> 15;
			if (w15 > 32767) w15 = 32767;
			t[i] = COEF_W'(w15);
		end
		return t;
	endfunction

	function automatic tw_tab_t build_tw_re();
		tw_tab_t t;
		sc_t v;
		for (int i = 0; i < HALF_LEN; i++) begin
			v    = sc_twid(i);
			t[i] = q30_to_q15(v.c);
		end
		return t;
	endfunction

	function automatic tw_tab_t build_tw_im();
		tw_tab_t t;
		sc_t v;
		for (int i = 0; i < HALF_LEN; i++) begin
			v    = sc_twid(i);
			t[i] = q30_to_q15(-v.s);
		end
		return t;
	endfunction

	localparam hann_tab_t HANN_TAB = build_hann();
	localparam tw_tab_t TW_RE_TAB  = build_tw_re();
	localparam tw_tab_t TW_IM_TAB  = build_tw_im();

	function automatic logic [FFT_BITS-1:0] bit_rev(input logic [FFT_BITS-1:0] v);
		logic [FFT_BITS-1:0] r;
		for (int b = 0; b < FFT_BITS; b++) r[b] = v[FFT_BITS-1-b];
		return r;
	endfunction

	function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [PROD_W:0] v);
		logic signed [DATA_W-1:0] r;
		if (v > DATA_MAX) r = DATA_W'(DATA_MAX);
		else if (v < DATA_MIN) r = DATA_W'(DATA_MIN);
		else r = DATA_W'(v);
		return r;
	endfunction

endpackage

### src/hfmb_ram.sv
// Generic RAM: one write port, two registered read ports.
module hfmb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

### src/hfmb_isqrt.sv
// Bit-serial integer square root, two radicand bits per cycle.
module hfmb_isqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [hfmb_pkg::RAD_W-1:0] radicand,
	output logic                       done,
	output logic [hfmb_pkg::ROOT_W-1:0] root
);
	import hfmb_pkg::*;

	logic [RAD_W-1:0] v_q;
	logic [RAD_W:0]   res_q;
	logic [RAD_W-1:0] bit_q;
	logic             run_q;
	logic             done_q;
	logic [RAD_W:0]   trial;

	assign trial = res_q + (RAD_W+1)'(bit_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= run_q && bit_q[0];
			if (start) run_q <= 1'b1;
			else if (bit_q[0]) run_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= radicand;
			res_q <= '0;
			bit_q <= RAD_W'(1) << (RAD_W - 2);
		end else if (run_q) begin
			if ((RAD_W+1)'(v_q) >= trial) begin
				v_q   <= RAD_W'((RAD_W+1)'(v_q) - trial);
				res_q <= (res_q >> 1) + (RAD_W+1)'(bit_q);
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[ROOT_W-1:0];

endmodule

### src/hann_fft_magnitude_bank_unit.sv
// Top level: Hann window, in-place radix-2 FFT and bin magnitudes over one frame.
//
// Doppler filter bank for one range cell. Each accepted word (start high, busy low) is one
// Q1.15 sample; it is scaled by its Hann coefficient and written bit-reversed into the frame
// RAM in states ST_WIN_MUL and ST_WIN_WR; busy stays high in both, so the next sample waits. The word
// that completes the frame starts the transform: (FFT_LEN/2)*log2(FFT_LEN) butterflies, all
// through one 25x25 multiplier and the frame RAM's single write port, then each bin's
// magnitude (two squares on the same multiplier plus a 25-step square root). Results appear
// as words of four bins with strobe high for exactly one cycle each; the receiver cannot
// stall them, so it must take every strobed word. last marks the final word of a frame.
// busy stays high through the transform and the last strobe.
module hann_fft_magnitude_bank_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [hfmb_pkg::SAMPLE_BITS-1:0] sample,
	output logic                              strobe,
	output logic [hfmb_pkg::BIN_W-1:0]        first_bin,
	output logic [hfmb_pkg::MAG_W-1:0]        mag_a,
	output logic [hfmb_pkg::MAG_W-1:0]        mag_b,
	output logic [hfmb_pkg::MAG_W-1:0]        mag_c,
	output logic [hfmb_pkg::MAG_W-1:0]        mag_d,
	output logic                              last
);
	import hfmb_pkg::*;

	typedef enum logic [9:0] {
		ST_IDLE    = 10'b0000000001,
		ST_WIN_MUL = 10'b0000000010,
		ST_WIN_WR  = 10'b0000000100,
		ST_BF_RD   = 10'b0000001000,
		ST_BF_MUL  = 10'b0000010000,
		ST_BF_WRA  = 10'b0000100000,
		ST_BF_WRB  = 10'b0001000000,
		ST_MG_RD   = 10'b0010000000,
		ST_MG_MUL  = 10'b0100000000,
		ST_MG_SQRT = 10'b1000000000
	} state_t;

	state_t state_q;
	logic [2:0] st_q;                 // micro-step inside multiply states

	logic [IDX_W-1:0]           pos_q;   // samples taken in the current frame
	logic signed [SAMPLE_BITS-1:0] smp_q;
	logic [STG_W-1:0]           stg_q;
	logic [FFT_BITS-2:0]        bfly_q;
	logic [FFT_BITS-1:0]        bin_q;

	logic signed [DATA_W-1:0] ar_q, ai_q, br_q, bi_q;
	logic signed [COEF_W-1:0] wr_q, wi_q;
	logic signed [PROD_W-1:0] prod_q, tr_q, ti_q;
	logic [RAD_W-1:0]         sq_q;

	logic strobe_q, last_q;
	logic [MAG_W-1:0] mag_a_q, mag_b_q, mag_c_q, mag_d_q;

	// butterfly addressing: insert a zero at bit stg to get the upper leg's partner
	logic [FFT_BITS-1:0] half_mask, jx, lo_idx, a_idx, b_idx, tw_wide;
	logic [FFT_BITS-2:0] tw_idx;

	assign half_mask = (FFT_BITS'(1) << stg_q) - FFT_BITS'(1);
	assign jx        = {1'b0, bfly_q};
	assign lo_idx    = jx & half_mask;
	assign a_idx     = ((jx & ~half_mask) << 1) | lo_idx;
	assign b_idx     = a_idx | (FFT_BITS'(1) << stg_q);
	assign tw_wide   = lo_idx << (FFT_BITS - 1 - int'(stg_q));
	assign tw_idx    = tw_wide[FFT_BITS-2:0];

	// shared multiplier
	logic signed [DATA_W-1:0] mul_a, mul_b;
	logic signed [PROD_W-1:0] mul_p;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_WIN_MUL: begin
				mul_a = {{(DATA_W-SAMPLE_BITS){smp_q[SAMPLE_BITS-1]}}, smp_q};
				mul_b = {{(DATA_W-COEF_W){1'b0}}, HANN_TAB[pos_q]};
			end
			ST_BF_MUL: begin
				case (st_q)
					3'd1: begin mul_a = br_q; mul_b = DATA_W'(wr_q); end
					3'd2: begin mul_a = bi_q; mul_b = DATA_W'(wi_q); end
					3'd3: begin mul_a = br_q; mul_b = DATA_W'(wi_q); end
					3'd4: begin mul_a = bi_q; mul_b = DATA_W'(wr_q); end
					default: begin mul_a = '0; mul_b = '0; end
				endcase
			end
			ST_MG_MUL: begin
				case (st_q)
					3'd1: begin mul_a = ar_q; mul_b = ar_q; end
					3'd2: begin mul_a = ai_q; mul_b = ai_q; end
					default: begin mul_a = '0; mul_b = '0; end
				endcase
			end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	always_ff @(posedge clk) begin
		prod_q <= mul_p;
	end

	// butterfly outputs a+t and a-t, rounded once and saturated
	logic signed [PROD_W-1:0] tr_rnd, ti_rnd, win_rnd;
	logic signed [DATA_W-1:0] na_re, na_im, nb_re, nb_im, win_val;

	assign tr_rnd  = (tr_q + ROUND_HALF) >>> 15;
	assign ti_rnd  = (ti_q + ROUND_HALF) >>> 15;
	assign win_rnd = (prod_q + ROUND_HALF) >>> 15;
	assign na_re   = sat_data((PROD_W+1)'(ar_q) + (PROD_W+1)'(tr_rnd));
	assign na_im   = sat_data((PROD_W+1)'(ai_q) + (PROD_W+1)'(ti_rnd));
	assign nb_re   = sat_data((PROD_W+1)'(ar_q) - (PROD_W+1)'(tr_rnd));
	assign nb_im   = sat_data((PROD_W+1)'(ai_q) - (PROD_W+1)'(ti_rnd));
	assign win_val = sat_data((PROD_W+1)'(win_rnd));

	// frame RAM
	logic                ram_we;
	logic [FFT_BITS-1:0] ram_waddr, ram_raddr_a;
	logic [CELL_W-1:0]   ram_wdata, ram_rdata_a, ram_rdata_b;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = a_idx;
		ram_wdata = {na_re, na_im};
		case (state_q)
			ST_WIN_WR: begin
				ram_we    = (int'(pos_q) < FFT_LEN);
				ram_waddr = bit_rev(pos_q[FFT_BITS-1:0]);
				ram_wdata = {win_val, {DATA_W{1'b0}}};
			end
			ST_BF_WRA: begin
				ram_we    = 1'b1;
				ram_waddr = a_idx;
				ram_wdata = {na_re, na_im};
			end
			ST_BF_WRB: begin
				ram_we    = 1'b1;
				ram_waddr = b_idx;
				ram_wdata = {nb_re, nb_im};
			end
			default: ram_we = 1'b0;
		endcase
	end

	assign ram_raddr_a = (state_q == ST_MG_RD) ? bin_q : a_idx;

	hfmb_ram #(
		.WIDTH(CELL_W),
		.DEPTH(FFT_LEN)
	) u_frame_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.raddr_a (ram_raddr_a),
		.rdata_a (ram_rdata_a),
		.raddr_b (b_idx),
		.rdata_b (ram_rdata_b)
	);

	// magnitude square root
	logic              sqrt_start, sqrt_done;
	logic [ROOT_W-1:0] sqrt_root;
	logic [MAG_W-1:0]  mag_sat;

	assign sqrt_start = (state_q == ST_MG_MUL) && (st_q == 3'd4);
	assign mag_sat    = sqrt_root[ROOT_W-1] ? '1 : sqrt_root[MAG_W-1:0];

	hfmb_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (sq_q),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	logic accept;
	assign accept = start && (state_q == ST_IDLE) && !strobe_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			st_q     <= '0;
			pos_q    <= '0;
			stg_q    <= '0;
			bfly_q   <= '0;
			bin_q    <= '0;
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) state_q <= ST_WIN_MUL;
				end
				ST_WIN_MUL: state_q <= ST_WIN_WR;
				ST_WIN_WR: begin
					if (int'(pos_q) == WINDOW - 1) begin
						pos_q   <= '0;
						stg_q   <= '0;
						bfly_q  <= '0;
						state_q <= ST_BF_RD;
					end else begin
						pos_q   <= pos_q + IDX_W'(1);
						state_q <= ST_IDLE;
					end
				end
				ST_BF_RD: begin
					st_q    <= '0;
					state_q <= ST_BF_MUL;
				end
				ST_BF_MUL: begin
					st_q <= st_q + 3'd1;
					if (st_q == 3'd5) state_q <= ST_BF_WRA;
				end
				ST_BF_WRA: state_q <= ST_BF_WRB;
				ST_BF_WRB: begin
					bfly_q <= bfly_q + (FFT_BITS-1)'(1);
					if (&bfly_q) begin
						if (int'(stg_q) == FFT_BITS - 1) begin
							bin_q   <= '0;
							state_q <= ST_MG_RD;
						end else begin
							stg_q   <= stg_q + STG_W'(1);
							state_q <= ST_BF_RD;
						end
					end else begin
						state_q <= ST_BF_RD;
					end
				end
				ST_MG_RD: begin
					st_q    <= '0;
					state_q <= ST_MG_MUL;
				end
				ST_MG_MUL: begin
					st_q <= st_q + 3'd1;
					if (st_q == 3'd4) state_q <= ST_MG_SQRT;
				end
				ST_MG_SQRT: begin
					if (sqrt_done) begin
						bin_q <= bin_q + FFT_BITS'(1);
						if (&bin_q[1:0]) begin
							strobe_q <= 1'b1;
							last_q   <= &bin_q;
						end
						state_q <= (&bin_q) ? ST_IDLE : ST_MG_RD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) smp_q <= sample;
		case (state_q)
			ST_BF_MUL: begin
				case (st_q)
					3'd0: begin
						ar_q <= ram_rdata_a[CELL_W-1:DATA_W];
						ai_q <= ram_rdata_a[DATA_W-1:0];
						br_q <= ram_rdata_b[CELL_W-1:DATA_W];
						bi_q <= ram_rdata_b[DATA_W-1:0];
						wr_q <= TW_RE_TAB[tw_idx];
						wi_q <= TW_IM_TAB[tw_idx];
					end
					3'd2: tr_q <= prod_q;
					3'd3: tr_q <= tr_q - prod_q;
					3'd4: ti_q <= prod_q;
					3'd5: ti_q <= ti_q + prod_q;
					default: ;
				endcase
			end
			ST_MG_MUL: begin
				case (st_q)
					3'd0: begin
						ar_q <= ram_rdata_a[CELL_W-1:DATA_W];
						ai_q <= ram_rdata_a[DATA_W-1:0];
					end
					3'd2: sq_q <= RAD_W'(prod_q);
					3'd3: sq_q <= sq_q + RAD_W'(prod_q);
					default: ;
				endcase
			end
			ST_MG_SQRT: begin
				if (sqrt_done) begin
					case (bin_q[1:0])
						2'd0: mag_a_q <= mag_sat;
						2'd1: mag_b_q <= mag_sat;
						2'd2: mag_c_q <= mag_sat;
						default: mag_d_q <= mag_sat;
					endcase
				end
			end
			default: ;
		endcase
	end

	logic [FFT_BITS-1:0] word_base;
	assign word_base = bin_q - FFT_BITS'(4);   // bin_q has already moved past the word

	assign busy      = (state_q != ST_IDLE) || strobe_q;
	assign strobe    = strobe_q;
	assign first_bin = BIN_W'({word_base[FFT_BITS-1:2], 2'b00});
	assign mag_a     = mag_a_q;
	assign mag_b     = mag_b_q;
	assign mag_c     = mag_c_q;
	assign mag_d     = mag_d_q;
	assign last      = last_q;

endmodule

### src/hfmb_checker.sv
// Port-level checker for the magnitude bank, bound to the top level.
module hfmb_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic                              strobe,
	input logic [hfmb_pkg::BIN_W-1:0]        first_bin,
	input logic                              last
);
	import hfmb_pkg::*;

	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy)
		else $error("result word without busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not raise busy");

	a_word_align: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (first_bin[1:0] == 2'b00))
		else $error("first_bin not a multiple of four");

	a_spaced: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |=> !strobe)
		else $error("back-to-back result words");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last) |=> !busy)
		else $error("busy held after the final word");

endmodule

bind hann_fft_magnitude_bank_unit hfmb_checker u_hfmb_checker (.*);

### bench/testbench.sv
// Self-checking bench for the Hann window FFT magnitude bank: directed table, random samples.
`timescale 1ns / 1ps

module testbench;
	import hfmb_pkg::*;

	localparam int N_RAND   = 255;     // random samples after the table
	localparam int N_BINS   = 256;
	localparam longint ONE30 = 64'sd1073741824;
	localparam longint QPI30 = 64'sd1686629713;

	typedef struct {
		logic [BIN_W-1:0] bin0;
		logic [MAG_W-1:0] mag [4];
		logic             fin;
	} bins_word_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic strobe;
	logic [BIN_W-1:0] first_bin;
	logic [MAG_W-1:0] mag_a, mag_b, mag_c, mag_d;
	logic last;

	hann_fft_magnitude_bank_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .sample(sample),
		.strobe(strobe), .first_bin(first_bin), .mag_a(mag_a), .mag_b(mag_b),
		.mag_c(mag_c), .mag_d(mag_d), .last(last)
	);

	// Predictor state: window and twiddle tables, the frame in bit-reversed order
	longint hann_w [N_BINS];
	longint twr [N_BINS/2];
	longint twi [N_BINS/2];
	longint fr_re [N_BINS];
	longint fr_im [N_BINS];
	int unsigned samples_held;
	bins_word_t bins_due [$];
	int mismatches;

	// Directed opening: full-scale extremes, single-bit and alternating patterns.
	// All land in the first frame, so none of them may produce a word yet.
	logic signed [SAMPLE_BITS-1:0] opening_samples [25] = '{
		16'sh0000, 16'sh7fff, -16'sh8000, 16'sh0001, -16'sh0001,
		16'sh5555, -16'sh5556, 16'sh7fff, 16'sh7fff, -16'sh8000,
		-16'sh8000, 16'sh0000, 16'sh4000, -16'sh4000, 16'sh0100,
		16'sh00ff, 16'sh7f00, -16'sh0100, 16'sh1234, -16'sh1234,
		16'sh2aaa, 16'sh3333, -16'sh3334, 16'sh7ffe, -16'sh7fff
	};

	// sin and cos at Q2.30 of 2*pi*m/d, Taylor series in the first quadrant
	task automatic turn_sin_cos(input int unsigned m, input int unsigned d,
			output longint s_o, output longint c_o);
		longint unsigned m4, q, r, x, x2, term;
		longint s, c;
		m4 = 4 * longint'(m % d);
		q  = m4 / d;
		r  = m4 - q * d;
		x  = (longint'(QPI30) * r + d / 2) / d;
		x2 = (x * x) >> 30;
		term = x;
		s = longint'(x);
		for (int n = 1; n <= 12; n++) begin
			term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
			s = (n % 2) ? s - longint'(term) : s + longint'(term);
		end
		term = ONE30;
		c = ONE30;
		for (int n = 1; n <= 12; n++) begin
			term = ((term * x2) >> 30) / longint'((2 * n - 1) * (2 * n));
			c = (n % 2) ? c - longint'(term) : c + longint'(term);
		end
		case (q % 4)
			0: begin s_o = s; c_o = c; end
			1: begin s_o = c; c_o = -s; end
			2: begin s_o = -s; c_o = -c; end
			default: begin s_o = -c; c_o = s; end
		endcase
	endtask

	function automatic longint to_q15(input longint v);
		longint t, r;
		t = (v > ONE30) ? ONE30 : (v < -ONE30) ? -ONE30 : v;
		r = ((t + ONE30 + 16384) >>> 15) - 32768;
		return (r > 32767) ? 32767 : (r < -32768) ? -32768 : r;
	endfunction

	function automatic longint rnd15(input longint v);
		return (v + 16384) >>> 15;
	endfunction

	function automatic longint clip25(input longint v);
		return (v > 16777215) ? 16777215 : (v < -16777216) ? -16777216 : v;
	endfunction

	function automatic longint unsigned int_root(input longint unsigned v);
		longint unsigned res, bt;
		res = 0;
		bt  = 64'd1 << 62;
		while (bt > v) bt >>= 2;
		while (bt != 0) begin
			if (v >= res + bt) begin
				v   = v - (res + bt);
				res = (res >> 1) + bt;
			end else
				res >>= 1;
			bt >>= 2;
		end
		return res;
	endfunction

	task automatic build_coeffs();
		longint s, c, w;
		for (int i = 0; i < N_BINS; i++) begin
			turn_sin_cos(i, N_BINS - 1, s, c);
			w = (ONE30 - c) / 2;
			if (w < 0) w = 0;
			w = (w + 16384) >>> 15;
			hann_w[i] = (w > 32767) ? 32767 : w;
		end
		for (int i = 0; i < N_BINS / 2; i++) begin
			turn_sin_cos(i, N_BINS, s, c);
			twr[i] = to_q15(c);
			twi[i] = to_q15(-s);
		end
	endtask

	// In-place radix-2 transform over the held frame, then queue the 64 words of bins
	task automatic transform_frame();
		longint wr, wi, ar, ai, tr, ti;
		int b;
		bins_word_t wd;
		longint unsigned sq;
		for (int len = 2; len <= N_BINS; len *= 2)
			for (int base = 0; base < N_BINS; base += len)
				for (int k = 0; k < len / 2; k++) begin
					b  = base + k + len / 2;
					wr = twr[k * (N_BINS / len)];
					wi = twi[k * (N_BINS / len)];
					ar = fr_re[base + k];
					ai = fr_im[base + k];
					tr = rnd15(fr_re[b] * wr - fr_im[b] * wi);
					ti = rnd15(fr_re[b] * wi + fr_im[b] * wr);
					fr_re[base + k] = clip25(ar + tr);
					fr_im[base + k] = clip25(ai + ti);
					fr_re[b] = clip25(ar - tr);
					fr_im[b] = clip25(ai - ti);
				end
		for (int r = 0; r < N_BINS / 4; r++) begin
			wd.bin0 = BIN_W'(r * 4);
			for (int j = 0; j < 4; j++) begin
				sq = longint'(fr_re[r*4+j] * fr_re[r*4+j] + fr_im[r*4+j] * fr_im[r*4+j]);
				sq = int_root(sq);
				wd.mag[j] = (sq > 64'd16777215) ? 24'hffffff : MAG_W'(sq);
			end
			wd.fin = (r == N_BINS / 4 - 1);
			bins_due.push_back(wd);
		end
	endtask

	// Window one accepted sample into its bit-reversed slot; the frame's final word fires the FFT
	task automatic take_sample(input logic signed [SAMPLE_BITS-1:0] v);
		int unsigned slot;
		slot = 0;
		for (int b = 0; b < 8; b++) slot[b] = samples_held[7 - b];
		fr_re[slot] = clip25(rnd15(longint'(v) * hann_w[samples_held]));
		fr_im[slot] = 0;
		samples_held++;
		if (samples_held == N_BINS) begin
			samples_held = 0;
			transform_frame();
		end
	endtask

	// Present one word and hold it until the block takes it
	task automatic send_word(input logic signed [SAMPLE_BITS-1:0] v, input bit may_idle);
		start  <= 1'b1;
		sample <= v;
		do @(posedge clk); while (busy);
		take_sample(v);
		if (may_idle && $urandom_range(99) < 13) begin
			start <= 1'b0;
			repeat ($urandom_range(6, 1)) @(posedge clk);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("TEST FAILED");
		$finish;
	end

	// Words leave the block unstallable: check every strobed word against the oldest due one
	always @(posedge clk) begin
		bins_word_t want;
		if (arst_n && strobe) begin
			if (bins_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: first_bin %0d last %0b", first_bin, last);
			end else begin
				want = bins_due.pop_front();
				if (first_bin !== want.bin0 || mag_a !== want.mag[0] ||
						mag_b !== want.mag[1] || mag_c !== want.mag[2] ||
						mag_d !== want.mag[3] || last !== want.fin) begin
					mismatches++;
					if (mismatches <= 10)
						$display("bins %0d: exp %0d %0d %0d %0d l%0b, got %0d: %0d %0d %0d %0d l%0b",
							want.bin0, want.mag[0], want.mag[1], want.mag[2],
							want.mag[3], want.fin, first_bin, mag_a, mag_b, mag_c,
							mag_d, last);
				end
			end
		end
	end

	initial begin
		logic signed [SAMPLE_BITS-1:0] v;
		int wait_cnt;
		mismatches   = 0;
		samples_held = 0;
		start  = 1'b0;
		sample = '0;
		arst_n = 1'b0;
		for (int i = 0; i < N_BINS; i++) begin
			fr_re[i] = 0;
			fr_im[i] = 0;
		end
		build_coeffs();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening_samples[i])
			send_word(opening_samples[i], 1'b1);

		// Random samples complete the first frame; a middle stretch runs back to back
		for (int i = 0; i < N_RAND; i++) begin
			case ($urandom_range(9))
				0:       v = $urandom_range(1) ? 16'sh7fff : -16'sh8000;
				1, 2:    v = SAMPLE_BITS'($signed($urandom_range(511)) - 256);
				default: v = SAMPLE_BITS'($urandom);
			endcase
			send_word(v, !(i >= 90 && i < 170));
		end

		// Hold off until the whole frame of bins has come out
		start <= 1'b0;
		wait_cnt = 0;
		while (bins_due.size() != 0 && wait_cnt < 40000) begin
			@(posedge clk);
			wait_cnt++;
		end

		// More samples of a frame that never completes: no word may follow
		for (int i = 0; i < 24; i++)
			send_word(SAMPLE_BITS'($urandom), 1'b1);
		start <= 1'b0;

		wait_cnt = 0;
		while (bins_due.size() != 0 && wait_cnt < 40000) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (200) @(posedge clk);
		if (mismatches == 0 && bins_due.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

### filelist.f
src/hfmb_pkg.sv
src/hfmb_ram.sv
src/hfmb_isqrt.sv
src/hann_fft_magnitude_bank_unit.sv
src/hfmb_checker.sv
bench/testbench.sv
